// ----- sv/ssp_pkg.sv -----
// Sprite screen projection: shared types and constants.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    localparam int MAX_SCREEN_DIM = 2048;

    // divider pipeline layout
    localparam int DEPTH_BITS  = 15;                     // depth quotient bits
    localparam int COL_QBITS   = 26;                     // column magnitude bits
    localparam int SH_QBITS    = 12;                     // height quotient bits
    localparam int SW_QBITS    = 24;                     // width quotient bits
    localparam int SW_START    = DEPTH_BITS;             // first width step
    localparam int SH_START    = DEPTH_BITS + 1;         // first height step
    localparam int DIV_STAGES  = SW_START + SW_QBITS;

    typedef enum logic [2:0] {
        REG_CAM_POS_X     = 3'd0,
        REG_CAM_POS_Y     = 3'd1,
        REG_VIEW_DIR_X    = 3'd2,
        REG_VIEW_DIR_Y    = 3'd3,
        REG_PLANE_X       = 3'd4,
        REG_PLANE_Y       = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] cam_x;
        logic signed [15:0] cam_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] pln_x;
        logic signed [15:0] pln_y;
        logic [11:0]        scr_w;
        logic [11:0]        scr_h;
    } cfg_t;

    // one word in flight through the divider pipeline
    typedef struct packed {
        logic        vis;
        logic [47:0] drem;   // depth remainder
        logic [31:0] dden;   // |det|
        logic [14:0] dq;
        logic        dsat;
        logic [45:0] crem;   // column remainder
        logic [33:0] cden;   // 2*num_y
        logic [25:0] cq;
        logic        csat;
        logic        cneg;
        logic [14:0] sden;   // max(depth, 1)
        logic [22:0] hrem;
        logic [11:0] shq;
        logic        shsat;
        logic [23:0] wrem;
        logic [23:0] swq;
        logic [11:0] h;
    } div_t;

endpackage

`default_nettype wire

// ----- sv/ssp_transform.sv -----
// Sprite screen projection: camera transform front end (five stages).
// Depends on ssp_pkg; feeds ssp_divide.
`timescale 1ns / 1ps
`default_nettype none

module ssp_transform (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_vld,
    input  wire logic signed [15:0] sprite_x,
    input  wire logic signed [15:0] sprite_y,
    input  wire logic [11:0]        sprite_height,
    input  wire logic [11:0]        sprite_radius,
    input  wire ssp_pkg::cfg_t      cfg,
    output logic                    out_vld,
    output ssp_pkg::div_t           out_st
);

    logic signed [15:0] cam_x, cam_y, dir_x, dir_y, pln_x, pln_y;
    assign cam_x = cfg.cam_x;
    assign cam_y = cfg.cam_y;
    assign dir_x = cfg.dir_x;
    assign dir_y = cfg.dir_y;
    assign pln_x = cfg.pln_x;
    assign pln_y = cfg.pln_y;

    // stage 1: offsets from camera
    logic               s1_vld_reg;
    logic signed [16:0] s1_dx_reg, s1_dy_reg, s1_dx_next, s1_dy_next;
    logic [11:0]        s1_hq_reg, s1_rq_reg;

    assign s1_dx_next = sprite_x - cam_x;
    assign s1_dy_next = sprite_y - cam_y;

    // stage 2: products
    logic               s2_vld_reg;
    logic signed [32:0] s2_pa_reg, s2_pb_reg, s2_pc_reg, s2_pd_reg, s2_det_reg;
    logic signed [32:0] s2_pa_next, s2_pb_next, s2_pc_next, s2_pd_next, s2_det_next;
    logic [11:0]        s2_wc_reg, s2_hc_reg, wc_next, hc_next;
    logic [22:0]        s2_hhq_reg, s2_hrq_reg, s2_hhq_next, s2_hrq_next;

    assign s2_pa_next  = dir_y * s1_dx_reg;
    assign s2_pb_next  = dir_x * s1_dy_reg;
    assign s2_pc_next  = pln_y * s1_dx_reg;
    assign s2_pd_next  = pln_x * s1_dy_reg;
    assign s2_det_next = pln_x * dir_y - dir_x * pln_y;

    always_comb
    begin
        wc_next = cfg.scr_w;
        if (cfg.scr_w == 12'd0)
            wc_next = 12'd1;
        else if (cfg.scr_w > 12'(ssp_pkg::MAX_SCREEN_DIM))
            wc_next = 12'(ssp_pkg::MAX_SCREEN_DIM);
        hc_next = cfg.scr_h;
        if (cfg.scr_h == 12'd0)
            hc_next = 12'd1;
        else if (cfg.scr_h > 12'(ssp_pkg::MAX_SCREEN_DIM))
            hc_next = 12'(ssp_pkg::MAX_SCREEN_DIM);
    end

    assign s2_hhq_next = hc_next * s1_hq_reg;
    assign s2_hrq_next = hc_next * s1_rq_reg;

    // stage 3: numerators, normalized to a positive determinant
    logic               s3_vld_reg, s3_dz_reg;
    logic signed [33:0] s3_nx_reg, s3_ny_reg, s3_nx_next, s3_ny_next, nx_raw, ny_raw;
    logic signed [32:0] det_neg;
    logic [31:0]        s3_dmag_reg, s3_dmag_next;
    logic [11:0]        s3_wc_reg, s3_hc_reg;
    logic [22:0]        s3_hhq_reg, s3_hrq_reg;

    assign nx_raw  = s2_pa_reg - s2_pb_reg;
    assign ny_raw  = s2_pd_reg - s2_pc_reg;
    assign det_neg = -s2_det_reg;

    always_comb
    begin
        if (s2_det_reg[32])
        begin
            s3_nx_next   = -nx_raw;
            s3_ny_next   = -ny_raw;
            s3_dmag_next = det_neg[31:0];
        end
        else
        begin
            s3_nx_next   = nx_raw;
            s3_ny_next   = ny_raw;
            s3_dmag_next = s2_det_reg[31:0];
        end
    end

    // stage 4: near test (depth > 1/20 is 1280*num_y > det), saturation, column sum
    logic               s4_vld_reg, s4_vis_reg, s4_dsat_reg;
    logic               vis_next, dsat_next;
    logic signed [44:0] ny_scaled;
    logic signed [34:0] s4_numc_reg, s4_numc_next;
    logic signed [33:0] s4_ny_reg;
    logic [31:0]        s4_dmag_reg;
    logic [11:0]        s4_wc_reg, s4_hc_reg;
    logic [22:0]        s4_hhq_reg, s4_hrq_reg;

    assign ny_scaled    = (s3_ny_reg <<< 10) + (s3_ny_reg <<< 8);
    assign vis_next     = !s3_dz_reg && (ny_scaled > $signed({13'b0, s3_dmag_reg}));
    assign dsat_next    = s3_ny_reg >= $signed({1'b0, s3_dmag_reg, 1'b0});
    assign s4_numc_next = s3_nx_reg + s3_ny_reg;

    // stage 5: column numerator magnitude, divider setup
    logic signed [34:0] numc_neg;
    logic [33:0]        cabs;
    logic [45:0]        cmag;
    ssp_pkg::div_t      st_next;

    assign numc_neg = -s4_numc_reg;
    assign cabs     = s4_numc_reg[34] ? numc_neg[33:0] : s4_numc_reg[33:0];
    assign cmag     = cabs * s4_wc_reg;

    always_comb
    begin
        st_next       = '0;
        st_next.vis   = s4_vis_reg;
        st_next.drem  = {1'b0, s4_ny_reg[32:0], 14'b0};
        st_next.dden  = s4_dmag_reg;
        st_next.dsat  = s4_dsat_reg;
        st_next.crem  = cmag;
        st_next.cden  = {s4_ny_reg[32:0], 1'b0};
        st_next.cneg  = s4_numc_reg[34];
        st_next.hrem  = s4_hhq_reg;
        st_next.wrem  = {s4_hrq_reg, 1'b0};
        st_next.h     = s4_hc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            out_vld    <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            out_vld    <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s1_hq_reg   <= sprite_height;
            s1_rq_reg   <= sprite_radius;

            s2_pa_reg   <= s2_pa_next;
            s2_pb_reg   <= s2_pb_next;
            s2_pc_reg   <= s2_pc_next;
            s2_pd_reg   <= s2_pd_next;
            s2_det_reg  <= s2_det_next;
            s2_wc_reg   <= wc_next;
            s2_hc_reg   <= hc_next;
            s2_hhq_reg  <= s2_hhq_next;
            s2_hrq_reg  <= s2_hrq_next;

            s3_nx_reg   <= s3_nx_next;
            s3_ny_reg   <= s3_ny_next;
            s3_dmag_reg <= s3_dmag_next;
            s3_dz_reg   <= (s2_det_reg == 33'sd0);
            s3_wc_reg   <= s2_wc_reg;
            s3_hc_reg   <= s2_hc_reg;
            s3_hhq_reg  <= s2_hhq_reg;
            s3_hrq_reg  <= s2_hrq_reg;

            s4_vis_reg  <= vis_next;
            s4_dsat_reg <= dsat_next;
            s4_numc_reg <= s4_numc_next;
            s4_ny_reg   <= s3_ny_reg;
            s4_dmag_reg <= s3_dmag_reg;
            s4_wc_reg   <= s3_wc_reg;
            s4_hc_reg   <= s3_hc_reg;
            s4_hhq_reg  <= s3_hhq_reg;
            s4_hrq_reg  <= s3_hrq_reg;

            out_st      <= st_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ssp_divide.sv -----
// Sprite screen projection: pipelined restoring dividers, one quotient bit per
// stage for depth, column, height and width. Depends on ssp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssp_divide (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_vld,
    input  wire ssp_pkg::div_t in_st,
    output logic               out_vld,
    output ssp_pkg::div_t      out_st
);

    localparam int N = ssp_pkg::DIV_STAGES;

    ssp_pkg::div_t pipe_reg [1:N];
    logic          vld_reg  [1:N];

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        // depth bits first; column runs alongside after its range check;
        // height and width start once the depth is known
        localparam int DI = (g < ssp_pkg::DEPTH_BITS) ? ssp_pkg::DEPTH_BITS - 1 - g : 0;
        localparam int CI = (g >= 1 && g <= ssp_pkg::COL_QBITS) ? ssp_pkg::COL_QBITS - g : 0;
        localparam int HI = (g >= ssp_pkg::SH_START && g < ssp_pkg::SH_START + ssp_pkg::SH_QBITS)
                            ? ssp_pkg::SH_START + ssp_pkg::SH_QBITS - 1 - g : 0;
        localparam int WI = (g >= ssp_pkg::SW_START) ? N - 1 - g : 0;

        ssp_pkg::div_t cur, nxt;
        logic          cur_vld;

        if (g == 0)
        begin : g_first
            assign cur     = in_st;
            assign cur_vld = in_vld;
        end
        else
        begin : g_rest
            assign cur     = pipe_reg[g];
            assign cur_vld = vld_reg[g];
        end

        always_comb
        begin
            nxt = cur;
            if (g < ssp_pkg::DEPTH_BITS)
            begin
                if ((cur.drem >> DI) >= 48'(cur.dden))
                begin
                    nxt.drem   = cur.drem - (48'(cur.dden) << DI);
                    nxt.dq[DI] = 1'b1;
                end
            end
            if (g == ssp_pkg::DEPTH_BITS - 1)
            begin
                nxt.sden = cur.dsat ? 15'h7FFF : nxt.dq;
                if (nxt.sden == 15'd0)
                    nxt.sden = 15'd1;
            end
            if (g == 0)
                nxt.csat = (cur.crem >> ssp_pkg::COL_QBITS) >= 46'(cur.cden);
            else if (g <= ssp_pkg::COL_QBITS)
            begin
                if ((cur.crem >> CI) >= 46'(cur.cden))
                begin
                    nxt.crem   = cur.crem - (46'(cur.cden) << CI);
                    nxt.cq[CI] = 1'b1;
                end
            end
            if (g == ssp_pkg::SW_START)
                nxt.shsat = (cur.hrem >> ssp_pkg::SH_QBITS) >= 23'(cur.sden);
            else if (g >= ssp_pkg::SH_START && g < ssp_pkg::SH_START + ssp_pkg::SH_QBITS)
            begin
                if ((cur.hrem >> HI) >= 23'(cur.sden))
                begin
                    nxt.hrem    = cur.hrem - (23'(cur.sden) << HI);
                    nxt.shq[HI] = 1'b1;
                end
            end
            if (g >= ssp_pkg::SW_START)
            begin
                if ((cur.wrem >> WI) >= 24'(cur.sden))
                begin
                    nxt.wrem    = cur.wrem - (24'(cur.sden) << WI);
                    nxt.swq[WI] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g+1] <= 1'b0;
            else if (adv)
                vld_reg[g+1] <= cur_vld;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                pipe_reg[g+1] <= nxt;
        end
    end

    assign out_vld = vld_reg[N];
    assign out_st  = pipe_reg[N];

endmodule

`default_nettype wire

// ----- sv/ssp_finish.sv -----
// Sprite screen projection: final assembly of spans and the output register.
// Depends on ssp_pkg; fed by ssp_divide.
`timescale 1ns / 1ps
`default_nettype none

module ssp_finish (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_vld,
    input  wire ssp_pkg::div_t in_st,
    output logic               out_vld,
    output logic               visible,
    output logic signed [15:0] screen_col,
    output logic [14:0]        view_depth,
    output logic signed [15:0] span_left,
    output logic signed [15:0] span_right,
    output logic [10:0]        span_top,
    output logic [10:0]        span_bottom
);

    function automatic logic [15:0] sat16(input logic signed [28:0] v);
        if (v > 29'sd32767)
            return 16'h7FFF;
        else if (v < -29'sd32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    logic [26:0]        cm;
    logic signed [27:0] col;
    logic signed [28:0] col_x, left, right, sw2;
    logic [12:0]        sh, bsum;
    logic [11:0]        sh2, hm1;
    logic [10:0]        hh, top, bot;
    logic [14:0]        depth;

    assign cm    = in_st.csat ? 27'(1 << ssp_pkg::COL_QBITS) : {1'b0, in_st.cq};
    assign col   = in_st.cneg ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
    assign col_x = {col[27], col};
    assign sw2   = $signed({6'b0, in_st.swq[23:1]});
    assign left  = col_x - sw2;
    assign right = col_x + sw2;

    assign sh    = in_st.shsat ? 13'd4096 : {1'b0, in_st.shq};
    assign sh2   = sh[12:1];
    assign hh    = in_st.h[11:1];
    assign hm1   = in_st.h - 12'd1;
    assign bsum  = {2'b0, hh} + {1'b0, sh2};
    assign top   = ({1'b0, hh} >= sh2) ? 11'({1'b0, hh} - sh2) : 11'd0;
    assign bot   = (bsum > {1'b0, hm1}) ? hm1[10:0] : bsum[10:0];
    assign depth = in_st.dsat ? 15'h7FFF : in_st.dq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld <= 1'b0;
        else if (adv)
            out_vld <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            visible     <= in_st.vis;
            screen_col  <= in_st.vis ? sat16(col_x) : 16'sd0;
            view_depth  <= in_st.vis ? depth : 15'd0;
            span_left   <= in_st.vis ? sat16(left) : 16'sd0;
            span_right  <= in_st.vis ? sat16(right) : 16'sd0;
            span_top    <= in_st.vis ? top : 11'd0;
            span_bottom <= in_st.vis ? bot : 11'd0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sprite_screen_projection_unit.sv -----
// Sprite screen projection: top level, configuration registers and flow control.
// Depends on ssp_pkg, ssp_transform, ssp_divide and ssp_finish.
`timescale 1ns / 1ps
`default_nettype none

// Projects one sprite per word into screen space for a raycasting renderer.
// Input channel (in_valid / in_stall): sprite position, height and radius.
// Output channel (out_valid / out_stall): visible flag, column, depth, spans.
// A word moves on a rising edge with valid high and stall low.
// Config channel (cfg_valid / cfg_ready): cfg_index selects camera position,
// direction, plane and screen size; cfg_ready is always high. Write config
// only while the pipeline is empty.
// Throughput: one word per cycle while the output is not stalled. A word
// passes through five transform stages (offset, multiply, normalize, near
// test, column product), 39 divider stages that each retire one quotient
// bit (depth first, then sprite height and width; the column runs alongside)
// and the output register on its way to out_valid.
// Stall: the whole pipeline advances together; while a result sits in the
// output register under out_stall, in_stall is raised and nothing moves, so
// no word is dropped or repeated. Bubbles flow through as invalid stages.
// Reset: all valid bits clear; config returns to its defaults (camera at
// origin looking along +x, plane 0.66 along +y, 640 x 480 screen).
module sprite_screen_projection_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] sprite_x,
    input  wire logic signed [15:0] sprite_y,
    input  wire logic [11:0]        sprite_height,
    input  wire logic [11:0]        sprite_radius,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    visible,
    output logic signed [15:0]      screen_col,
    output logic [14:0]             view_depth,
    output logic signed [15:0]      span_left,
    output logic signed [15:0]      span_right,
    output logic [10:0]             span_top,
    output logic [10:0]             span_bottom,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    ssp_pkg::cfg_t cfg_reg;
    logic          adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_x <= 16'sd0;
            cfg_reg.cam_y <= 16'sd0;
            cfg_reg.dir_x <= 16'sd16384;
            cfg_reg.dir_y <= 16'sd0;
            cfg_reg.pln_x <= 16'sd0;
            cfg_reg.pln_y <= 16'sd10813;
            cfg_reg.scr_w <= 12'd640;
            cfg_reg.scr_h <= 12'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ssp_pkg::reg_idx_t'(cfg_index))
                ssp_pkg::REG_CAM_POS_X:     cfg_reg.cam_x <= cfg_data;
                ssp_pkg::REG_CAM_POS_Y:     cfg_reg.cam_y <= cfg_data;
                ssp_pkg::REG_VIEW_DIR_X:    cfg_reg.dir_x <= cfg_data;
                ssp_pkg::REG_VIEW_DIR_Y:    cfg_reg.dir_y <= cfg_data;
                ssp_pkg::REG_PLANE_X:       cfg_reg.pln_x <= cfg_data;
                ssp_pkg::REG_PLANE_Y:       cfg_reg.pln_y <= cfg_data;
                ssp_pkg::REG_SCREEN_WIDTH:  cfg_reg.scr_w <= cfg_data[11:0];
                ssp_pkg::REG_SCREEN_HEIGHT: cfg_reg.scr_h <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves unless a held result is stalled
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    logic          xf_vld, dv_vld;
    ssp_pkg::div_t xf_st, dv_st;

    ssp_transform u_transform (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_vld        (in_valid),
        .sprite_x      (sprite_x),
        .sprite_y      (sprite_y),
        .sprite_height (sprite_height),
        .sprite_radius (sprite_radius),
        .cfg           (cfg_reg),
        .out_vld       (xf_vld),
        .out_st        (xf_st)
    );

    ssp_divide u_divide (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (xf_vld),
        .in_st   (xf_st),
        .out_vld (dv_vld),
        .out_st  (dv_st)
    );

    ssp_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_vld      (dv_vld),
        .in_st       (dv_st),
        .out_vld     (out_valid),
        .visible     (visible),
        .screen_col  (screen_col),
        .view_depth  (view_depth),
        .span_left   (span_left),
        .span_right  (span_right),
        .span_top    (span_top),
        .span_bottom (span_bottom)
    );

    // no input is taken while a finished word is held back
    a_no_accept_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !(out_valid && out_stall))
        else $error("input accepted while output stalled");

    // hidden sprites carry all-zero fields
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (screen_col == 16'sd0 && view_depth == 15'd0 &&
        span_left == 16'sd0 && span_right == 16'sd0 &&
        span_top == 11'd0 && span_bottom == 11'd0))
        else $error("hidden sprite with nonzero fields");

    // vertical span never inverts
    a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && visible) |-> (span_top <= span_bottom))
        else $error("span_top below span_bottom");

    // horizontal span never inverts
    a_cols_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && visible) |-> (span_left <= span_right))
        else $error("span_left right of span_right");

endmodule

`default_nettype wire

// ----- sim/sprite_screen_projection_unit_test.sv -----
// Testbench for sprite_screen_projection_unit: directed and random sprites
// under several camera and screen settings, checked by a scoreboard class.
// Depends on ssp_pkg and the sprite_screen_projection_unit RTL.
`timescale 1ns / 1ps

module sprite_screen_projection_unit_test;

    // one expected projection result
    typedef struct {
        logic        vis;
        logic [15:0] col;
        logic [14:0] depth;
        logic [15:0] left;
        logic [15:0] right;
        logic [10:0] top;
        logic [10:0] bottom;
    } proj_t;

    // Keeps its own copy of the camera registers, predicts each accepted
    // sprite and checks results in order.
    class projection_board;
        ssp_pkg::cfg_t cam;
        proj_t         pending[$];
        int            fails;
        int            checked;
        int            seen_visible;

        function new();
            cam.cam_x = 16'sd0;
            cam.cam_y = 16'sd0;
            cam.dir_x = 16'sd16384;
            cam.dir_y = 16'sd0;
            cam.pln_x = 16'sd0;
            cam.pln_y = 16'sd10813;
            cam.scr_w = 12'd640;
            cam.scr_h = 12'd480;
            fails = 0;
            checked = 0;
            seen_visible = 0;
        endfunction

        function void set_reg(ssp_pkg::reg_idx_t idx, logic [15:0] d);
            case (idx)
                ssp_pkg::REG_CAM_POS_X:     cam.cam_x = d;
                ssp_pkg::REG_CAM_POS_Y:     cam.cam_y = d;
                ssp_pkg::REG_VIEW_DIR_X:    cam.dir_x = d;
                ssp_pkg::REG_VIEW_DIR_Y:    cam.dir_y = d;
                ssp_pkg::REG_PLANE_X:       cam.pln_x = d;
                ssp_pkg::REG_PLANE_Y:       cam.pln_y = d;
                ssp_pkg::REG_SCREEN_WIDTH:  cam.scr_w = d[11:0];
                ssp_pkg::REG_SCREEN_HEIGHT: cam.scr_h = d[11:0];
                default: ;
            endcase
        endfunction

        static function logic [15:0] sat16(longint v);
            if (v < -32768) return 16'h8000;
            if (v > 32767) return 16'h7fff;
            return v[15:0];
        endfunction

        // note an accepted sprite: inverse camera transform and projection
        function void note_sprite(logic [15:0] sx, logic [15:0] sy,
                                  logic [11:0] hq, logic [11:0] rq);
            longint dx, dy, w, h, det, nx, ny, n, depth, col, d, sh, sw, top, bot;
            longint cx, cy, vx, vy, px, py;
            proj_t  p;
            cx = longint'($signed(cam.cam_x));
            cy = longint'($signed(cam.cam_y));
            vx = longint'($signed(cam.dir_x));
            vy = longint'($signed(cam.dir_y));
            px = longint'($signed(cam.pln_x));
            py = longint'($signed(cam.pln_y));
            dx = longint'($signed(sx)) - cx;
            dy = longint'($signed(sy)) - cy;
            w = (cam.scr_w == 0) ? 1 : (cam.scr_w > ssp_pkg::MAX_SCREEN_DIM) ?
                ssp_pkg::MAX_SCREEN_DIM : cam.scr_w;
            h = (cam.scr_h == 0) ? 1 : (cam.scr_h > ssp_pkg::MAX_SCREEN_DIM) ?
                ssp_pkg::MAX_SCREEN_DIM : cam.scr_h;
            det = px * vy - vx * py;
            nx = vy * dx - vx * dy;
            ny = -py * dx + px * dy;
            p = '{default: '0};
            if (det < 0)
            begin
                det = -det;
                nx = -nx;
                ny = -ny;
            end
            n = ny * 16384;
            // near limit: depth must exceed 0.05 world units exactly
            if (det != 0 && 20 * n > det * 256)
            begin
                depth = n / det;
                if (depth > 32767) depth = 32767;
                col = (w * (nx + ny)) / (2 * ny);
                d = (depth < 1) ? 1 : depth;
                sh = (h * hq * 256) / (d * 256);
                sw = (2 * h * rq * 256) / (d * 256);
                top = h / 2 - sh / 2;
                if (top < 0) top = 0;
                bot = h / 2 + sh / 2;
                if (bot > h - 1) bot = h - 1;
                p.vis = 1'b1;
                p.col = sat16(col);
                p.depth = depth[14:0];
                p.left = sat16(col - sw / 2);
                p.right = sat16(col + sw / 2);
                p.top = top[10:0];
                p.bottom = bot[10:0];
            end
            pending.insert(pending.size(), p);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
            fails++;
        endtask

        task check_result(proj_t r);
            proj_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (e.vis) seen_visible++;
            if (r.vis !== e.vis) report("visible", r.vis, e.vis);
            if (r.col !== e.col) report("screen_col", r.col, e.col);
            if (r.depth !== e.depth) report("view_depth", r.depth, e.depth);
            if (r.left !== e.left) report("span_left", r.left, e.left);
            if (r.right !== e.right) report("span_right", r.right, e.right);
            if (r.top !== e.top) report("span_top", r.top, e.top);
            if (r.bottom !== e.bottom) report("span_bottom", r.bottom, e.bottom);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] sprite_x;
    logic signed [15:0] sprite_y;
    logic [11:0]        sprite_height;
    logic [11:0]        sprite_radius;
    logic               out_valid;
    logic               out_stall;
    logic               visible;
    logic signed [15:0] screen_col;
    logic [14:0]        view_depth;
    logic signed [15:0] span_left;
    logic signed [15:0] span_right;
    logic [10:0]        span_top;
    logic [10:0]        span_bottom;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    projection_board board = new();
    int              sent = 0;
    int              phases = 0;
    int              stall_pct = 0;
    int              stall_hold = 0;
    int              stall_cycle = 0;

    sprite_screen_projection_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sprite_x(sprite_x), .sprite_y(sprite_y),
        .sprite_height(sprite_height), .sprite_radius(sprite_radius),
        .out_valid(out_valid), .out_stall(out_stall),
        .visible(visible), .screen_col(screen_col), .view_depth(view_depth),
        .span_left(span_left), .span_right(span_right),
        .span_top(span_top), .span_bottom(span_bottom),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Gap length: mostly none or short, a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Receiver side: the stall rate is redrawn at regular intervals, including
    // stretches with no stall at all, plus an occasional long hold.
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 300 == 0)
            stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 199) == 0)
        begin
            stall_hold <= $urandom_range(10, 50);
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result monitor: values seen here are those sampled at the edge.
    always @(posedge clk)
    begin
        proj_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            r.vis = visible;
            r.col = screen_col;
            r.depth = view_depth;
            r.left = span_left;
            r.right = span_right;
            r.top = span_top;
            r.bottom = span_bottom;
            board.check_result(r);
        end
    end

    // Holds cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(ssp_pkg::reg_idx_t idx, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(idx, d);
    endtask

    // Send one sprite word; the gap before it is random.
    task automatic send_sprite(logic [15:0] sx, logic [15:0] sy,
                               logic [11:0] hq, logic [11:0] rq);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sprite_x <= sx;
        sprite_y <= sy;
        sprite_height <= hq;
        sprite_radius <= rq;
        do
            @(posedge clk);
        while (in_stall);
        board.note_sprite(sx, sy, hq, rq);
        sent++;
    endtask

    // Drain the pipeline so the registers can change safely.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic load_camera(logic [15:0] cx, logic [15:0] cy, logic [15:0] vx,
                               logic [15:0] vy, logic [15:0] px, logic [15:0] py,
                               logic [15:0] sw, logic [15:0] sh);
        drain();
        write_reg(ssp_pkg::REG_CAM_POS_X, cx);
        write_reg(ssp_pkg::REG_CAM_POS_Y, cy);
        write_reg(ssp_pkg::REG_VIEW_DIR_X, vx);
        write_reg(ssp_pkg::REG_VIEW_DIR_Y, vy);
        write_reg(ssp_pkg::REG_PLANE_X, px);
        write_reg(ssp_pkg::REG_PLANE_Y, py);
        write_reg(ssp_pkg::REG_SCREEN_WIDTH, sw);
        write_reg(ssp_pkg::REG_SCREEN_HEIGHT, sh);
        cfg_valid <= 1'b0;
        phases++;
    endtask

    // Random sprite: mostly near the camera so it tends to be visible,
    // the rest anywhere in the world.
    task automatic random_sprite();
        logic [15:0] sx, sy;
        logic [11:0] hq, rq;
        if ($urandom_range(0, 9) < 7)
        begin
            sx = board.cam.cam_x + 16'($urandom_range(0, 8191)) - 16'd4096;
            sy = board.cam.cam_y + 16'($urandom_range(0, 8191)) - 16'd4096;
        end
        else
        begin
            sx = 16'($urandom);
            sy = 16'($urandom);
        end
        hq = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(64, 1024));
        rq = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(16, 512));
        send_sprite(sx, sy, hq, rq);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        sprite_x <= '0;
        sprite_y <= '0;
        sprite_height <= '0;
        sprite_radius <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ssp_pkg::REG_CAM_POS_X;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: camera at origin facing +x, so
        // depth equals the x offset. 12 LSB is at the near limit, 13 is past it.
        send_sprite(16'sd12, 16'sd0, 12'd256, 12'd128);
        send_sprite(16'sd13, 16'sd0, 12'd256, 12'd128);
        send_sprite(16'sd13, 16'sd0, 12'hfff, 12'hfff);
        send_sprite(16'sd256, 16'sd0, 12'd0, 12'd0);
        send_sprite(16'sh7fff, 16'sh7fff, 12'hfff, 12'hfff);
        send_sprite(16'sh7fff, 16'sh8000, 12'd1, 12'd1);
        send_sprite(16'sh8000, 16'sd0, 12'd256, 12'd256);
        send_sprite(16'sd256, 16'sh7fff, 12'd256, 12'd256);
        send_sprite(16'sd20, 16'sh8000, 12'd256, 12'd256);
        send_sprite(16'sd0, 16'sd0, 12'd256, 12'd256);
        send_sprite(16'sd512, 16'sd100, 12'd300, 12'd200);

        // Zero determinant: nothing is visible.
        load_camera(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd10813, 16'd640, 16'd480);
        send_sprite(16'sd512, 16'sd0, 12'd256, 12'd256);
        send_sprite(16'sd0, 16'sd512, 12'd256, 12'd256);

        // Screen size out of range both ways, camera at the corner.
        load_camera(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                    16'd0, 16'hfff);
        send_sprite(16'sh8100, 16'sh7e00, 12'hfff, 12'hfff);
        send_sprite(16'sh7fff, 16'sh8000, 12'hfff, 12'hfff);
        load_camera(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd10813,
                    16'hfff, 16'd0);
        send_sprite(16'sd64, 16'sd10, 12'hfff, 12'hfff);
        send_sprite(16'sd1000, 16'sh8000, 12'd256, 12'd256);
        load_camera(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd10813,
                    16'd2048, 16'd2048);
        send_sprite(16'sd13, 16'sd0, 12'hfff, 12'hfff);
        send_sprite(16'sd2000, 16'sd300, 12'd1, 12'd1);

        // Random phases: back at reset values, then random cameras.
        load_camera(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd10813, 16'd640, 16'd480);
        repeat (150) random_sprite();
        for (int ph = 0; ph < 10; ph++)
        begin
            load_camera(16'($urandom), 16'($urandom),
                        ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 32767)),
                        16'($urandom), 16'($urandom), 16'($urandom),
                        ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2048)),
                        ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2048)));
            repeat (100) random_sprite();
        end

        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Checked %0d projections (%0d visible) from %0d sprites", board.checked,
                 board.seen_visible, sent);
        $display("over %0d camera and screen settings; %0d mismatches", phases, board.fails);
        if (board.fails == 0)
            $display("sprite_screen_projection_unit_test: PASS");
        else
            $display("sprite_screen_projection_unit_test: FAIL");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2000000;
        $display("Timed out with %0d results outstanding", board.pending.size());
        $display("sprite_screen_projection_unit_test: FAIL");
        $finish;
    end

endmodule
